@@ rtl/core/i2c_master_bit_engine_assert.svh @@
// Assertion macros shared by the I2C master bit engine RTL.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("i2c bit engine: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define I2CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("i2c bit engine: next-cycle check failed");

`endif

@@ rtl/core/i2cbe_pkg.sv @@
// Package for the I2C master bit engine: action codes, item type, defaults.
// Used by every module of the block; depends on nothing.
package i2cbe_pkg;

	// Action codes of an input transaction.
	localparam logic [2:0] ACT_TICK     = 3'd0;
	localparam logic [2:0] ACT_START    = 3'd1;
	localparam logic [2:0] ACT_STOP     = 3'd2;
	localparam logic [2:0] ACT_WRITE    = 3'd3;
	localparam logic [2:0] ACT_READ     = 3'd4;
	localparam logic [2:0] ACT_SEND_ACK = 3'd5;
	localparam logic [2:0] ACT_RECV_ACK = 3'd6;
	localparam logic [2:0] ACT_SPARE    = 3'd7;

	// Reset value of the delay unit register.
	localparam logic [15:0] UNIT_TICKS_RESET = 16'd100;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Bit positions of the result fields in m_tdata.
	localparam int OUT_SCL  = 0;
	localparam int OUT_SDA  = 1;
	localparam int OUT_BUSY = 2;
	localparam int OUT_DONE = 3;

	// Classified item as it travels from front to back.
	typedef struct packed {
		logic       is_cmd;
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       ack_drive;
		logic       sda_in;
	} item_t;

endpackage

@@ rtl/core/i2cbe_front.sv @@
// Front stage of the I2C master bit engine: accepts and classifies items.
// Depends on i2cbe_pkg; feeds i2cbe_queue.
module i2cbe_front
	import i2cbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] ack_drive, [9] sda_in, [15:10] zero
	input  logic [2:0]  s_tuser,   // [2:0] action
	output logic        item_valid_s1,
	output item_t       item_s1,
	input  logic        item_ready
);

	logic  is_cmd;
	item_t item_d;

	// Sort the action into commands and ticks; the spare code counts as a tick.
	always_comb begin
		unique case (s_tuser) inside
			ACT_START, ACT_STOP, ACT_WRITE, ACT_READ, ACT_SEND_ACK, ACT_RECV_ACK: begin
				is_cmd = 1'b1;
			end
			default: begin
				is_cmd = 1'b0;
			end
		endcase
	end

	always_comb begin
		item_d.is_cmd    = is_cmd;
		item_d.cmd       = s_tuser;
		item_d.tx_byte   = s_tdata[7:0];
		item_d.ack_drive = s_tdata[8];
		item_d.sda_in    = s_tdata[9];
	end

	// The stage takes a new item whenever it is empty or being emptied.
	assign s_tready = !item_valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ rtl/core/i2cbe_queue.sv @@
// Small first-in first-out queue of classified items between front and back.
// Depends on i2cbe_pkg for the item type.
module i2cbe_queue
	import i2cbe_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ rtl/core/i2cbe_back.sv @@
// Back stage of the I2C master bit engine: runs the SCL/SDA phase sequencer
// one item per cycle while its output register is free or being taken, and holds the result there.
// Depends on i2cbe_pkg; fed by i2cbe_queue.
module i2cbe_back
	import i2cbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] scl_level, [1] sda_level, [2] busy_res,
	                               // [3] done_res, [11:4] rx_byte, [12] ack_seen,
	                               // [15:13] zero
);

	// Number of phases of each command.
	function automatic logic [4:0] phase_count(input logic [2:0] cmd);
		logic [4:0] n;
		unique case (cmd) inside
			ACT_START:           n = 5'd2;
			ACT_STOP:            n = 5'd1;
			ACT_WRITE, ACT_READ: n = 5'd16;
			ACT_SEND_ACK:        n = 5'd1;
			default:             n = 5'd3;
		endcase
		return n;
	endfunction

	// Commands whose phases last two delay units.
	function automatic logic two_units(input logic [2:0] cmd);
		logic r;
		unique case (cmd) inside
			ACT_WRITE, ACT_SEND_ACK, ACT_RECV_ACK: r = 1'b1;
			default:                               r = 1'b0;
		endcase
		return r;
	endfunction

	// Line levels {scl, sda} while in a phase of a command.
	function automatic logic [1:0] phase_levels(input logic [2:0] cmd, input logic [4:0] ph,
		input logic [7:0] sh);
		logic [1:0] lv;
		unique case (cmd) inside
			ACT_START:    lv = {1'b1, (ph == 5'd0)};
			ACT_STOP:     lv = 2'b10;
			ACT_WRITE:    lv = {!ph[0], sh[3'd7 - ph[3:1]]};
			ACT_READ:     lv = {!ph[0], 1'b1};
			ACT_SEND_ACK: lv = {1'b1, !sh[0]};
			default:      lv = {(ph != 5'd0), 1'b1};
		endcase
		return lv;
	endfunction

	// Line levels {scl, sda} once a command has ended.
	function automatic logic [1:0] end_levels(input logic [2:0] cmd);
		logic [1:0] lv;
		unique case (cmd) inside
			ACT_START: lv = 2'b00;
			ACT_STOP:  lv = 2'b11;
			default:   lv = 2'b01;
		endcase
		return lv;
	endfunction

	logic [15:0] unit_ticks_q;
	logic        running_q;
	logic [2:0]  cmd_q;
	logic [4:0]  phase_q;
	logic [7:0]  shift_q;
	logic [16:0] count_q;
	logic [1:0]  lines_q;
	logic        ack_q;
	logic [7:0]  rx_q;
	logic        out_valid_q;
	logic [15:0] out_data_q;

	logic        running_d;
	logic [2:0]  cmd_d;
	logic [4:0]  phase_d;
	logic [7:0]  shift_d;
	logic [16:0] count_d;
	logic [1:0]  lines_d;
	logic        ack_d;
	logic [7:0]  rx_d;
	logic        done_d;

	logic [15:0] unit;
	logic [16:0] target;
	logic [16:0] count_inc;
	logic [4:0]  phase_inc;
	logic        end_now;
	logic        load;

	// Delay unit register; zero acts as one tick per unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RESET;
		end else if (cfg_write) begin
			unit_ticks_q <= cfg_data;
		end
	end

	assign unit      = (unit_ticks_q == 16'd0) ? 16'd1 : unit_ticks_q;
	assign target    = two_units(cmd_q) ? {unit, 1'b0} : {1'b0, unit};
	assign count_inc = count_q + 17'd1;
	assign phase_inc = phase_q + 5'd1;

	// Next state of the sequencer for the item at the head of the queue.
	always_comb begin
		running_d = running_q;
		cmd_d     = cmd_q;
		phase_d   = phase_q;
		shift_d   = shift_q;
		count_d   = count_q;
		lines_d   = lines_q;
		ack_d     = ack_q;
		rx_d      = rx_q;
		done_d    = 1'b0;
		end_now   = 1'b0;
		if (item.is_cmd) begin
			// A command starts only from idle; while busy it is dropped.
			if (!running_q) begin
				running_d = 1'b1;
				cmd_d     = item.cmd;
				phase_d   = 5'd0;
				count_d   = '0;
				if (item.cmd == ACT_WRITE) begin
					shift_d = item.tx_byte;
				end else if (item.cmd == ACT_SEND_ACK) begin
					shift_d = {7'd0, item.ack_drive};
				end else if (item.cmd == ACT_READ) begin
					shift_d = 8'd0;
				end
				lines_d = phase_levels(item.cmd, 5'd0, shift_d);
			end
		end else if (running_q) begin
			if (count_inc >= target) begin
				// End of a phase: sample, then move on or finish.
				count_d = '0;
				if (cmd_q == ACT_READ && !phase_q[0]) begin
					shift_d = {shift_q[6:0], item.sda_in};
				end
				if (cmd_q == ACT_RECV_ACK && phase_q == 5'd1) begin
					ack_d   = !item.sda_in;
					end_now = !item.sda_in;
				end
				if (end_now || phase_inc >= phase_count(cmd_q)) begin
					lines_d   = end_levels(cmd_q);
					running_d = 1'b0;
					phase_d   = 5'd0;
					done_d    = 1'b1;
					if (cmd_q == ACT_READ) begin
						rx_d = shift_d;
					end
				end else begin
					phase_d = phase_inc;
					lines_d = phase_levels(cmd_q, phase_inc, shift_d);
				end
			end else begin
				count_d = count_inc;
			end
		end
	end

	// One item moves on whenever the output register is free or being taken.
	assign load       = item_valid && (!out_valid_q || m_tready);
	assign item_ready = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			cmd_q       <= ACT_TICK;
			phase_q     <= '0;
			shift_q     <= '0;
			count_q     <= '0;
			lines_q     <= 2'b11;
			ack_q       <= 1'b0;
			rx_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				running_q <= running_d;
				cmd_q     <= cmd_d;
				phase_q   <= phase_d;
				shift_q   <= shift_d;
				count_q   <= count_d;
				lines_q   <= lines_d;
				ack_q     <= ack_d;
				rx_q      <= rx_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register: levels and status after the item.
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {3'd0, ack_d, rx_d, done_d, running_d, lines_d[0], lines_d[1]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ rtl/core/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: front stage, item queue, sequencer.
// Depends on i2cbe_pkg, i2cbe_front, i2cbe_queue, i2cbe_back and the assert header.
//
// Channel   Direction  Signals                       Carries
// s_        in         s_tvalid s_tready s_tdata/user one tick or command per transaction
// m_        out        m_tvalid m_tready m_tdata      line levels and status per item
// cfg_      in         cfg_valid cfg_ready cfg_data   unit_ticks register write
//
// One item is taken per clock while s_tready is high; each gives one result after passing
// the front register, the queue and the sequencer output register.
// The sequencer updates its phase counter and levels once for each item it takes.
// Reset clears all control state at once; there is no clearing pass.
// A stalled m_ side fills the queue and then drops s_tready; cfg_ready is always high.
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine
	import i2cbe_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] ack_drive, [9] sda_in, [15:10] zero
	input  logic [2:0]  s_tuser,   // [2:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
	                               // [3] done_res, [11:4] rx_byte, [12] ack_seen,
	                               // [15:13] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic  front_valid;
	logic  front_ready;
	item_t front_item;
	logic  queue_valid;
	logic  queue_ready;
	item_t queue_item;

	assign cfg_ready = 1'b1;

	// Classify incoming transactions.
	i2cbe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.item_valid_s1 (front_valid),
		.item_s1       (front_item),
		.item_ready    (front_ready)
	);

	// Decouple the two sides.
	i2cbe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	// Run the bus phases.
	i2cbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.item_valid (queue_valid),
		.item_ready (queue_ready),
		.item       (queue_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	// A finishing item always reports the engine as free again.
	`I2CBE_ASSERT_NOW(a_done_not_busy, clk, arst_n, m_tvalid && m_tdata[OUT_DONE], !m_tdata[OUT_BUSY])

	// An accepted input transaction sits in the front register on the next cycle.
	`I2CBE_ASSERT_NEXT(a_accept_lands, clk, arst_n, s_tvalid && s_tready, front_valid)

	// No item leaves the queue while the result register is held by the sink.
	`I2CBE_ASSERT_NOW(a_no_pop_on_stall, clk, arst_n, m_tvalid && !m_tready, !queue_ready)

endmodule
